/* src/nasd_pkg.sv */
// shared types and constants for the nnue accumulator / screlu dot core
// no dependencies; imported by every module of the block except nasd_ram
package nasd_pkg;

	localparam int HIDDEN_SIZE_DEF = 256;
	localparam int ENTRY_W         = 16;
	localparam int INDEX_W         = 8;
	localparam int CLAMP_W         = 15;
	localparam int SQ_W            = 2 * CLAMP_W;
	localparam int SUM_W           = 32;
	localparam int CFG_ADDR_W      = 3;
	localparam int CFG_DATA_W      = 32;

	localparam logic [CLAMP_W-1:0] CLAMP_MAX_RST = CLAMP_W'(255);

	// register index of clamp_max, taken from paddr[2]
	localparam logic REG_CLAMP_MAX = 1'b0;

	typedef enum logic [1:0] {
		ACT_ADD  = 2'd0,
		ACT_SUB  = 2'd1,
		ACT_EVAL = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic load_item;
		logic clr_wr;
		logic upd_wr;
		logic sq_en;
		logic prod_en;
		logic sum_add;
	} dp_cmd_t;

	typedef struct packed {
		logic    clr_last;
		logic    in_range;
		action_t action;
		logic    last;
		logic    out_free;
	} dp_sts_t;

endpackage

/* src/nasd_ram.sv */
// generic single-write, single-read RAM with registered read data
// depends on nothing; used for the accumulator store
module nasd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/nasd_ctrl.sv */
// controller state machine: clearing pass, item sequencing, result hand-off
// depends on nasd_pkg
module nasd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  nasd_pkg::dp_sts_t sts,
	output nasd_pkg::dp_cmd_t cmd
);
	import nasd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_READ;
				end
			end
			ST_READ: begin
				// entry is on the ram output now
				unique case (sts.action)
					ACT_ADD, ACT_SUB: begin
						cmd.upd_wr = sts.in_range;
						state_d    = ST_IDLE;
					end
					ACT_EVAL: begin
						cmd.sq_en = 1'b1;
						state_d   = ST_MUL;
					end
					ACT_NONE: begin
						state_d = ST_IDLE;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_MUL: begin
				cmd.prod_en = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				// a last item waits until the output register can take the sum
				if (!sts.last || sts.out_free) begin
					cmd.sum_add = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/nasd_dp.sv */
// datapath: item registers, accumulator ram, clamp/square/weight pipeline,
// running sum and output register; depends on nasd_pkg and nasd_ram
module nasd_dp #(
	parameter int HIDDEN_SIZE = nasd_pkg::HIDDEN_SIZE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nasd_pkg::dp_cmd_t                   cmd,
	output nasd_pkg::dp_sts_t                   sts,
	input  logic [nasd_pkg::CLAMP_W-1:0]        clamp_max,
	input  logic [1:0]                          action,
	input  logic [nasd_pkg::INDEX_W-1:0]        index,
	input  logic signed [nasd_pkg::ENTRY_W-1:0] element_value,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [nasd_pkg::SUM_W-1:0]   eval_sum
);
	import nasd_pkg::*;

	localparam int AW = $clog2(HIDDEN_SIZE);
	localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;

	action_t                     act_q;
	logic [INDEX_W-1:0]          idx_q;
	logic signed [ENTRY_W-1:0]   val_q;
	logic                        last_q;
	logic                        in_range_q;
	logic [AW-1:0]               clr_cnt_q;
	logic [XW-1:0]               rd_idx_x;
	logic [XW-1:0]               wr_idx_x;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [ENTRY_W-1:0]          ram_wdata;
	logic [ENTRY_W-1:0]          ram_rdata;
	logic [ENTRY_W-1:0]          upd_val;
	logic [ENTRY_W-1:0]          entry;
	logic [CLAMP_W-1:0]          clamped;
	logic [SQ_W-1:0]             sq_s1;
	logic signed [SQ_W+ENTRY_W:0] prod_full;
	logic [SUM_W-1:0]            prod_s2;
	logic [SUM_W-1:0]            sum_next;
	logic [SUM_W-1:0]            sum_q;
	logic [SUM_W-1:0]            out_q;
	logic                        out_valid_q;
	logic                        emit;

	assign rd_idx_x = XW'(index);
	assign wr_idx_x = XW'(idx_q);

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q      <= action_t'(action);
			idx_q      <= index;
			val_q      <= element_value;
			last_q     <= last;
			in_range_q <= 32'(index) < 32'(HIDDEN_SIZE);
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	assign upd_val   = (act_q == ACT_ADD) ? ram_rdata + $unsigned(val_q)
	                                      : ram_rdata - $unsigned(val_q);
	assign ram_we    = cmd.clr_wr | (cmd.upd_wr & in_range_q);
	assign ram_waddr = cmd.clr_wr ? clr_cnt_q : wr_idx_x[AW-1:0];
	assign ram_wdata = cmd.clr_wr ? '0 : upd_val;

	nasd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HIDDEN_SIZE)
	) u_acc_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.load_item),
		.raddr(rd_idx_x[AW-1:0]),
		.rdata(ram_rdata)
	);

	// clipped activation: negative to zero, capped at clamp_max
	assign entry = in_range_q ? ram_rdata : '0;

	always_comb begin
		if (entry[ENTRY_W-1]) begin
			clamped = '0;
		end else if (entry[CLAMP_W-1:0] > clamp_max) begin
			clamped = clamp_max;
		end else begin
			clamped = entry[CLAMP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			sq_s1 <= clamped * clamped;
		end
	end

	assign prod_full = $signed({1'b0, sq_s1}) * val_q;

	always_ff @(posedge clk) begin
		if (cmd.prod_en) begin
			prod_s2 <= prod_full[SUM_W-1:0];
		end
	end

	assign sum_next = sum_q + prod_s2;
	assign emit     = cmd.sum_add & last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= emit ? '0 : sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign eval_sum  = $signed(out_q);

	assign sts.clr_last = (clr_cnt_q == AW'(HIDDEN_SIZE - 1));
	assign sts.in_range = in_range_q;
	assign sts.action   = act_q;
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

/* src/nnue_accumulator_screlu_dot_core.sv */
// top level of the nnue accumulator with squared clipped-relu dot product
// depends on nasd_pkg, nasd_ctrl, nasd_dp (and through it nasd_ram)
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------
//   input    | in_valid / in_stall         | action, index, element_value, last
//   output   | out_valid / out_stall       | eval_sum
//   config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// one transaction at a time: add and subtract do the accumulator ram's registered read
// and a write-back; evaluate does that read, then the square stage and the weight stage
// after reset a clearing pass zeroes every accumulator entry while in_stall is high;
// configuration writes are taken throughout
// the result sits in an output register, so the next item is accepted while it
// waits; an evaluate marked last holds in its final step until that register frees
module nnue_accumulator_screlu_dot_core #(
	parameter int HIDDEN_SIZE = nasd_pkg::HIDDEN_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [nasd_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [nasd_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [nasd_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                   pready,
	// input items
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             action,
	input  logic [nasd_pkg::INDEX_W-1:0]           index,
	input  logic signed [nasd_pkg::ENTRY_W-1:0]    element_value,
	input  logic                                   last,
	// results
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [nasd_pkg::SUM_W-1:0]      eval_sum
);
	import nasd_pkg::*;

	logic [CLAMP_W-1:0] clamp_max_q;
	logic               cfg_wr;
	dp_cmd_t            cmd;
	dp_sts_t            sts;

	// apb register: clamp_max at byte address 0, always ready
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_max_q <= CLAMP_MAX_RST;
		end else if (cfg_wr && (paddr[2] == REG_CLAMP_MAX)) begin
			clamp_max_q <= pwdata[CLAMP_W-1:0];
		end
	end

	// reads outside the register list return zero
	assign prdata = (paddr[2] == REG_CLAMP_MAX) ? CFG_DATA_W'(clamp_max_q) : '0;

	// sequencing: clear pass, accept, read, square, weight, accumulate
	nasd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// storage and arithmetic
	nasd_dp #(
		.HIDDEN_SIZE(HIDDEN_SIZE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.clamp_max    (clamp_max_q),
		.action       (action),
		.index        (index),
		.element_value(element_value),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.eval_sum     (eval_sum)
	);

`ifndef ASSERT_OFF
	// one transaction at a time: an accepted item blocks the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item was in flight");

	// a held result is never overwritten by the next sum
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sum_add && sts.last) |-> sts.out_free)
		else $error("sum emitted while the output register was still full");

	// an emitted sum shows up as a valid result on the next cycle
	a_emit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sum_add && sts.last) |=> out_valid)
		else $error("emitted sum did not reach the output");

	// the clearing pass never overlaps an accepted item
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> (in_stall && !cmd.load_item && !cmd.upd_wr))
		else $error("item activity during the clearing pass");
`endif

endmodule

/* test/tb_top.sv */
// self-checking testbench for nnue_accumulator_screlu_dot_core
// depends on nasd_pkg and the rtl of the block; drives random and directed transactions
// and checks every eval_sum against its own accumulator and running-sum predictor
module tb_top;
	import nasd_pkg::*;

	localparam int HIDDEN_SIZE  = HIDDEN_SIZE_DEF;
	localparam int MAX_GAP      = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 300000;

	// byte address of clamp_max on the config port
	localparam logic [CFG_ADDR_W-1:0] CLAMP_ADDR = {REG_CLAMP_MAX, 2'b00};

	typedef struct packed {
		action_t                    act;
		logic [INDEX_W-1:0]         idx;
		logic signed [ENTRY_W-1:0]  val;
		logic                       lst;
	} feat_item_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// config port
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr   = '0;
	logic [CFG_DATA_W-1:0] pwdata  = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// input channel
	logic                       in_valid      = 1'b0;
	logic                       in_stall;
	logic [1:0]                 action        = ACT_NONE;
	logic [INDEX_W-1:0]         index         = '0;
	logic signed [ENTRY_W-1:0]  element_value = '0;
	logic                       last          = 1'b0;

	// output channel
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SUM_W-1:0]    eval_sum;

	// stimulus and prediction state
	feat_item_t           tx_items[$];
	logic [SUM_W-1:0]     pending_sums[$];
	logic [ENTRY_W-1:0]   acc_model[HIDDEN_SIZE];
	logic [SUM_W-1:0]     sum_model  = '0;
	logic [CLAMP_W-1:0]   clamp_model = CLAMP_MAX_RST;

	// handshake bookkeeping
	logic in_took  = 1'b0;
	logic out_took = 1'b0;
	bit   idle_on       = 1'b1;
	bit   pressure_on   = 1'b0;
	bit   pressure_done = 1'b0;
	int   gap_left   = 0;
	int   stall_left = 0;
	int   hold_left  = 0;

	// statistics
	int n_items   = 0;
	int n_results = 0;
	int n_errors  = 0;
	int n_writes  = 0;
	int cycle_count = 0;

	nnue_accumulator_screlu_dot_core #(
		.HIDDEN_SIZE(HIDDEN_SIZE)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.index        (index),
		.element_value(element_value),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.eval_sum     (eval_sum)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// idle cycles drawn per transaction, none while idling is switched off
	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, MAX_GAP) : 0;
	endfunction

	// mirrors one accepted transaction: updates the accumulator copy and the
	// running sum, queueing the sum when an evaluate closes the dot product
	task automatic step_accumulator(feat_item_t it);
		int               entry;
		int               weight;
		logic [SUM_W-1:0] clamped;
		logic [SUM_W-1:0] square;
		bit               in_range;
		in_range = int'(it.idx) < HIDDEN_SIZE;
		case (it.act)
			ACT_ADD: begin
				if (in_range)
					acc_model[it.idx] = acc_model[it.idx] + it.val;
			end
			ACT_SUB: begin
				if (in_range)
					acc_model[it.idx] = acc_model[it.idx] - it.val;
			end
			ACT_EVAL: begin
				// entry outside the store reads as zero but last still emits
				entry  = in_range ? int'($signed(acc_model[it.idx])) : 0;
				weight = it.val;
				if (entry < 0)
					clamped = '0;
				else if (entry > int'(clamp_model))
					clamped = SUM_W'(clamp_model);
				else
					clamped = SUM_W'(entry);
				// exact product, wrapped to 32 bits, never truncated to 16
				square    = clamped * clamped;
				sum_model = sum_model + square * SUM_W'(weight);
				if (it.lst) begin
					pending_sums.push_back(sum_model);
					sum_model = '0;
				end
			end
			default: ; // unused action code does nothing
		endcase
	endtask

	function automatic feat_item_t mk_item(action_t a, int i, int v, bit l);
		feat_item_t it;
		it.act = a;
		it.idx = INDEX_W'(i);
		it.val = ENTRY_W'(v);
		it.lst = l;
		return it;
	endfunction

	// small pool half of the time so back-to-back updates hit the same entry
	function automatic int pick_index();
		return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
	endfunction

	function automatic int pick_delta();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 300);
			1: begin
				case ($urandom_range(0, 3))
					0: return 32767;
					1: return -32768;
					2: return -1;
					default: return 1;
				endcase
			end
			default: return int'($signed(16'($urandom())));
		endcase
	endfunction

	// mostly well-formed update runs closed by an evaluate run with last on its
	// final element; the rest is noise with any action and any last bit
	task automatic gen_random(int n);
		int count;
		int n_upd;
		int n_eval;
		action_t a;
		count = 0;
		while (count < n) begin
			if ($urandom_range(0, 9) < 8) begin
				n_upd  = $urandom_range(0, 4);
				n_eval = $urandom_range(1, 6);
				for (int j = 0; j < n_upd; j++) begin
					a = ($urandom_range(0, 1) == 0) ? ACT_ADD : ACT_SUB;
					tx_items.push_back(mk_item(a, pick_index(), pick_delta(),
						$urandom_range(0, 1)));
				end
				for (int j = 0; j < n_eval; j++)
					tx_items.push_back(mk_item(ACT_EVAL, pick_index(),
						int'($signed(16'($urandom()))), j == n_eval - 1));
				count += n_upd + n_eval;
			end else begin
				a = action_t'($urandom_range(0, 3));
				tx_items.push_back(mk_item(a, $urandom_range(0, 255),
					int'($signed(16'($urandom()))), $urandom_range(0, 1)));
				if (a != ACT_NONE)
					count++;
			end
		end
	endtask

	// waits until every transaction went in and every sum came out, then lets
	// trailing updates retire before the next config access
	task automatic wait_drained();
		while (tx_items.size() != 0 || in_valid || pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write clamp_max (upper pwdata bits are don't-care) and read it back
	task automatic write_clamp(logic [CFG_DATA_W-1:0] data);
		logic [CFG_DATA_W-1:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CLAMP_ADDR;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		clamp_model = data[CLAMP_W-1:0];
		n_writes++;
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {{(CFG_DATA_W-CLAMP_W){1'b0}}, clamp_model}) begin
			$display("%0t clamp_max readback mismatch: expected %0d, actual %0d",
				$time, clamp_model, rd);
			n_errors++;
		end
	endtask

	// driver: a new transaction is offered only once the previous one was taken
	always @(negedge clk) begin : drive_proc
		feat_item_t cur;
		bit         offer;
		if (in_valid && in_took)
			gap_left = draw_gap();
		if (!in_valid || in_took) begin
			offer = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (tx_items.size() > 0) begin
				cur   = tx_items.pop_front();
				offer = 1'b1;
				action        <= cur.act;
				index         <= cur.idx;
				element_value <= cur.val;
				last          <= cur.lst;
			end
			in_valid <= offer;
		end
	end

	// receiver: random stall after each result, plus one long hold-off
	always @(negedge clk) begin : recv_proc
		if (pressure_on && !pressure_done) begin
			hold_left     = HOLD_CYCLES;
			pressure_done = 1'b1;
		end
		if (out_took)
			stall_left = draw_gap();
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// monitor: predict on input transactions, check on output transactions
	always @(posedge clk) begin : mon_proc
		feat_item_t seen;
		logic [SUM_W-1:0] want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				seen.act = action_t'(action);
				seen.idx = index;
				seen.val = element_value;
				seen.lst = last;
				step_accumulator(seen);
				n_items++;
			end
			if (out_valid && !out_stall) begin
				n_results++;
				if (pending_sums.size() == 0) begin
					$display("%0t eval_sum mismatch: expected none, actual %0d",
						$time, eval_sum);
					n_errors++;
				end else begin
					want = pending_sums.pop_front();
					if (eval_sum !== want) begin
						$display("%0t eval_sum mismatch: expected %0d, actual %0d",
							$time, $signed(want), eval_sum);
						n_errors++;
					end
				end
			end
		end
		in_took  <= arst_n && in_valid && !in_stall;
		out_took <= arst_n && out_valid && !out_stall;
	end

	// run watchdog
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d sums outstanding", $time, pending_sums.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : main_seq
		logic [CFG_DATA_W-1:0] cfg;
		for (int i = 0; i < HIDDEN_SIZE; i++)
			acc_model[i] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset clamp of 255; the 8-bit index can never
		// go past the 256-entry store, so out-of-range reads are not reachable
		tx_items.push_back(mk_item(ACT_EVAL, 0,   -32768, 1)); // empty entry
		tx_items.push_back(mk_item(ACT_ADD,  0,    32767, 1)); // last ignored on add
		tx_items.push_back(mk_item(ACT_EVAL, 0,    32767, 1)); // clamped at the top
		tx_items.push_back(mk_item(ACT_SUB,  1,   -32768, 0)); // wraps to most negative
		tx_items.push_back(mk_item(ACT_EVAL, 1,        1, 1)); // negative clamps to zero
		tx_items.push_back(mk_item(ACT_ADD,  255,    100, 0)); // back-to-back same entry
		tx_items.push_back(mk_item(ACT_ADD,  255,    100, 0));
		tx_items.push_back(mk_item(ACT_EVAL, 255,     -1, 1));
		tx_items.push_back(mk_item(ACT_NONE, 7,        5, 1)); // unused code, last set
		tx_items.push_back(mk_item(ACT_NONE, 8,       -5, 0));
		tx_items.push_back(mk_item(ACT_ADD,  2,      255, 0)); // exactly at the clamp
		tx_items.push_back(mk_item(ACT_EVAL, 2,    32767, 0));
		tx_items.push_back(mk_item(ACT_EVAL, 0,   -32768, 0));
		tx_items.push_back(mk_item(ACT_EVAL, 255,  12345, 1));
		tx_items.push_back(mk_item(ACT_ADD,  3,    32767, 0)); // entry wrap on add
		tx_items.push_back(mk_item(ACT_ADD,  3,        1, 0));
		tx_items.push_back(mk_item(ACT_EVAL, 3,        2, 1));
		tx_items.push_back(mk_item(ACT_SUB,  4,        1, 1)); // last ignored on sub
		tx_items.push_back(mk_item(ACT_SUB,  4,       -1, 0));
		tx_items.push_back(mk_item(ACT_ADD,  4,      256, 0)); // one above the clamp
		tx_items.push_back(mk_item(ACT_EVAL, 4,       -1, 1));
		tx_items.push_back(mk_item(ACT_EVAL, 255,    777, 0)); // eval, then update, then eval
		tx_items.push_back(mk_item(ACT_SUB,  255,    200, 0));
		tx_items.push_back(mk_item(ACT_EVAL, 255,    777, 1));
		wait_drained();

		// widest clamp, with junk in the unused pwdata bits
		write_clamp(32'hFFFF_8000 | 32'(32767));
		idle_on = 1'b1;
		tx_items.push_back(mk_item(ACT_ADD,  5,  32767, 0));
		tx_items.push_back(mk_item(ACT_EVAL, 5,  32767, 0)); // product and sum wrap
		tx_items.push_back(mk_item(ACT_EVAL, 5, -32768, 0));
		tx_items.push_back(mk_item(ACT_EVAL, 0,  32767, 1));
		gen_random(70);
		wait_drained();

		// zero clamp, no idling on either side
		write_clamp(32'(0));
		idle_on = 1'b0;
		gen_random(50);
		wait_drained();

		write_clamp(32'(1));
		idle_on = 1'b1;
		gen_random(50);
		wait_drained();

		// back-pressure: the receiver holds off while closing evaluates pile up
		write_clamp(32'($urandom_range(0, 32767)));
		idle_on     = 1'b0;
		pressure_on = 1'b1;
		for (int i = 0; i < 30; i++)
			tx_items.push_back(mk_item(ACT_EVAL, pick_index(),
				int'($signed(16'($urandom()))), 1));
		gen_random(30);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			cfg = ($urandom() & 32'hFFFF_8000) | 32'($urandom_range(0, 32767));
			write_clamp(cfg);
			idle_on = ph[0];
			gen_random(35);
			wait_drained();
		end

		// back to the reset value
		write_clamp(32'(CLAMP_MAX_RST));
		idle_on = 1'b1;
		gen_random(20);
		wait_drained();

		$display("covered %0d input transactions and %0d checked sums over %0d clamp writes",
			n_items, n_results, n_writes);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
